[sv/circular_keyed_list_engine_defines.svh]
// Assertion macros for the circular keyed list engine.
// Relies on i_clk and i_rst_n in the module that uses them.
`ifndef CIRCULAR_KEYED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_KEYED_LIST_ENGINE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CKL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ckl_pkg.sv]
// Types and codes shared by the circular keyed list engine.
// No dependencies.
`default_nettype none
package ckl_pkg;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_RM_HEAD = 3'd2,
        OP_RM_KEY  = 3'd3,
        OP_SEARCH  = 3'd4,
        OP_NEXT    = 3'd5,
        OP_COUNT   = 3'd6,
        OP_LIST    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_op         opcode;
        logic [15:0] ticket_key;
        logic [15:0] customer_handle;
        logic [7:0]  ride_handle;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [15:0] entry_key;
        logic [15:0] entry_customer;
        logic [7:0]  entry_ride;
        logic [5:0]  entry_count;
        logic        last_result;
    } t_out_beat;

endpackage
`default_nettype wire

[sv/ckl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ckl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/circular_keyed_list_engine.sv]
// The list operation delivers one entry per cycle while the output is free.
// One item at a time; a key walk reads one linked entry per cycle from the entry and link RAMs.
// A new beat is taken only in the idle state, after the previous reply has been issued.
// Reset: synchronous, active low; empties the list. RAM contents are not cleared.
// Depends on ckl_pkg, ckl_ram and circular_keyed_list_engine_defines.svh.
`default_nettype none
`include "circular_keyed_list_engine_defines.svh"
module circular_keyed_list_engine
    import ckl_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_BITS + 24;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEEK   = 8'b0000_0010,
        ST_NEXT   = 8'b0000_0100,
        ST_UNLINK = 8'b0000_1000,
        ST_LIST   = 8'b0001_0000,
        ST_INS    = 8'b0010_0000,
        ST_INS2   = 8'b0100_0000,
        ST_REPLY  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [15:0]         r_cust, n_cust;
    logic [7:0]          r_ride, n_ride;
    logic [SW-1:0]       r_head, n_head, r_tail, n_tail;
    logic [SW-1:0]       r_cur, n_cur, r_prev, n_prev, r_slot, n_slot;
    logic [SW-1:0]       r_hit_link, n_hit_link;
    logic [CW-1:0]       r_count, n_count, r_idx, n_idx;
    logic [CAPACITY-1:0] r_used, n_used;
    t_status             r_res_status, n_res_status;
    logic                r_res_zero, n_res_zero;
    logic [DW-1:0]       r_res_data, n_res_data;
    t_out_beat           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic          d_we, l_we;
    logic [SW-1:0] d_waddr, l_waddr, l_wdata, rd_addr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [SW-1:0] l_rdata;
    logic [SW-1:0] free_slot;
    logic          free_found;
    logic          out_free, accept, walk_end;
    logic [CW-1:0] idx_inc;

    ckl_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (rd_addr),
        .o_rdata (d_rdata)
    );

    ckl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (rd_addr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!free_found && !r_used[i]) begin
                free_slot  = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign idx_inc  = r_idx + CW'(1);
    assign walk_end = (idx_inc == r_count);

    function automatic t_out_beat make_beat(input t_status st, input logic zero,
                                            input logic [DW-1:0] data,
                                            input logic [CW-1:0] cnt, input logic last);
        t_out_beat b;
        b.status         = st;
        b.entry_key      = zero ? 16'd0 : 16'(data[DW-1 -: KEY_BITS]);
        b.entry_customer = zero ? 16'd0 : data[23:8];
        b.entry_ride     = zero ? 8'd0  : data[7:0];
        b.entry_count    = 6'(cnt);
        b.last_result    = last;
        return b;
    endfunction

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_cust       = r_cust;
        n_ride       = r_ride;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_slot       = r_slot;
        n_hit_link   = r_hit_link;
        n_count      = r_count;
        n_idx        = r_idx;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_zero   = r_res_zero;
        n_res_data   = r_res_data;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        d_we         = 1'b0;
        d_waddr      = r_slot;
        d_wdata      = {r_key, r_cust, r_ride};
        l_we         = 1'b0;
        l_waddr      = r_slot;
        l_wdata      = r_slot;
        rd_addr      = r_cur;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op         = i_in_beat.opcode;
                    n_key        = KEY_BITS'(i_in_beat.ticket_key);
                    n_cust       = i_in_beat.customer_handle;
                    n_ride       = i_in_beat.ride_handle;
                    n_idx        = '0;
                    n_cur        = r_head;
                    n_prev       = r_tail;
                    rd_addr      = r_head;
                    n_res_zero   = 1'b1;
                    n_res_status = STS_OK;
                    unique case (i_in_beat.opcode)
                        OP_APPEND, OP_INSERT: begin
                            if (r_count >= CAP_C) begin
                                n_res_status = STS_FULL;
                                n_state      = ST_REPLY;
                            end else begin
                                n_slot  = free_slot;
                                n_state = ST_INS;
                            end
                        end
                        OP_COUNT: begin
                            n_state = ST_REPLY;
                        end
                        OP_RM_HEAD, OP_RM_KEY, OP_SEARCH, OP_NEXT, OP_LIST: begin
                            if (r_count == '0) begin
                                n_res_status = STS_EMPTY;
                                n_state      = ST_REPLY;
                            end else if (i_in_beat.opcode == OP_LIST) begin
                                n_state = ST_LIST;
                            end else begin
                                n_state = ST_SEEK;
                            end
                        end
                    endcase
                end
            end
            ST_SEEK: begin
                if (r_op == OP_RM_HEAD || d_rdata[DW-1 -: KEY_BITS] == r_key) begin
                    n_hit_link   = l_rdata;
                    n_res_data   = d_rdata;
                    n_res_zero   = 1'b0;
                    n_res_status = STS_OK;
                    priority if (r_op == OP_SEARCH) begin
                        n_state = ST_REPLY;
                    end else if (r_op == OP_NEXT) begin
                        rd_addr = l_rdata;
                        n_cur   = l_rdata;
                        n_state = ST_NEXT;
                    end else begin
                        n_state = ST_UNLINK;
                    end
                end else if (walk_end) begin
                    n_res_status = STS_NOT_FOUND;
                    n_state      = ST_REPLY;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = l_rdata;
                    rd_addr = l_rdata;
                    n_idx   = idx_inc;
                end
            end
            ST_NEXT: begin
                n_res_data = d_rdata;
                n_state    = ST_REPLY;
            end
            ST_UNLINK: begin
                priority if (r_count <= CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else if (r_cur == r_head) begin
                    n_head  = r_hit_link;
                    l_we    = 1'b1;
                    l_waddr = r_tail;
                    l_wdata = r_hit_link;
                end else begin
                    l_we    = 1'b1;
                    l_waddr = r_prev;
                    l_wdata = r_hit_link;
                    if (r_cur == r_tail) begin
                        n_tail = r_prev;
                    end
                end
                n_used[r_cur] = 1'b0;
                n_count       = r_count - CW'(1);
                n_state       = ST_REPLY;
            end
            ST_INS: begin
                d_we    = 1'b1;
                l_we    = 1'b1;
                l_wdata = (r_count == '0) ? r_slot : r_head;
                n_state = ST_INS2;
            end
            ST_INS2: begin
                if (r_count == '0) begin
                    n_head = r_slot;
                    n_tail = r_slot;
                end else begin
                    l_we    = 1'b1;
                    l_waddr = r_tail;
                    if (r_op == OP_APPEND) begin
                        n_tail = r_slot;
                    end else begin
                        n_head = r_slot;
                    end
                end
                n_used[r_slot] = 1'b1;
                n_count        = r_count + CW'(1);
                n_res_data     = {r_key, r_cust, r_ride};
                n_res_zero     = 1'b0;
                n_res_status   = STS_OK;
                n_state        = ST_REPLY;
            end
            ST_LIST: begin
                if (out_free) begin
                    n_out       = make_beat(STS_OK, 1'b0, d_rdata, r_count, walk_end);
                    n_out_valid = 1'b1;
                    if (walk_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cur   = l_rdata;
                        rd_addr = l_rdata;
                        n_idx   = idx_inc;
                    end
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_out = make_beat(r_res_status, r_res_zero, r_res_data, r_count, 1'b1);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_cust       <= n_cust;
        r_ride       <= n_ride;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_slot       <= n_slot;
        r_hit_link   <= n_hit_link;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_zero   <= n_res_zero;
        r_res_data   <= n_res_data;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `CKL_ASSERT_IMPL(a_count_matches_map, 1'b1, $countones(r_used) == r_count, "map/count mismatch")
    `CKL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CAP_C, "count above capacity")
    `CKL_ASSERT_IMPL(a_walk_in_range, (r_state == ST_SEEK || r_state == ST_LIST), r_idx < r_count, "walk past list end")
    `CKL_ASSERT_IMPL(a_error_zero, (o_out_valid && o_out_beat.status != STS_OK), (o_out_beat.entry_key == 16'd0 && o_out_beat.entry_customer == 16'd0 && o_out_beat.entry_ride == 8'd0), "error beat carries entry")

endmodule
`default_nettype wire

[bench/circular_keyed_list_engine_tb.sv]
// Self-checking bench for the circular keyed list engine: random and directed beats
// are checked against a behavioral list model kept in the bench.
// Depends on ckl_pkg and the circular_keyed_list_engine RTL.
`default_nettype none
module circular_keyed_list_engine_tb;
    import ckl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    circular_keyed_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    logic [15:0] m_key [CAP];
    logic [15:0] m_cust [CAP];
    logic [7:0]  m_ride [CAP];
    logic [4:0]  m_link [CAP];
    logic [CAP-1:0] m_used;
    logic [4:0]  m_head;
    logic [4:0]  m_tail;
    int          m_count;

    t_in_beat  pending_beats [$];
    t_out_beat expected_beats [$];
    int        failures;
    bit        stim_done;
    bit        long_hold;
    bit        drain_req;

    function automatic t_out_beat make_result(t_status st, int slot, bit last);
        t_out_beat r;
        r.status = st;
        if (slot >= 0) begin
            r.entry_key = m_key[slot];
            r.entry_customer = m_cust[slot];
            r.entry_ride = m_ride[slot];
        end else begin
            r.entry_key = '0;
            r.entry_customer = '0;
            r.entry_ride = '0;
        end
        r.entry_count = 6'(m_count);
        r.last_result = last;
        return r;
    endfunction

    function automatic int find_first(logic [15:0] key, output logic [4:0] prev);
        logic [4:0] cur;
        logic [4:0] p;
        cur = m_head;
        p = m_tail;
        prev = '0;
        for (int i = 0; i < m_count; i++) begin
            if (m_key[cur] == key) begin
                prev = p;
                return int'(cur);
            end
            p = cur;
            cur = m_link[cur];
        end
        return -1;
    endfunction

    task automatic apply_list_op(t_in_beat b);
        int s;
        logic [4:0] prev;
        logic [4:0] cur;
        s = -1;
        prev = '0;
        case (b.opcode)
            OP_APPEND, OP_INSERT: begin
                if (m_count >= CAP) begin
                    expected_beats.push_back(make_result(STS_FULL, -1, 1'b1));
                end else begin
                    for (int i = CAP - 1; i >= 0; i--)
                        if (!m_used[i]) s = i;
                    m_key[s] = b.ticket_key;
                    m_cust[s] = b.customer_handle;
                    m_ride[s] = b.ride_handle;
                    m_used[s] = 1'b1;
                    if (m_count == 0) begin
                        m_head = 5'(s);
                        m_tail = 5'(s);
                        m_link[s] = 5'(s);
                    end else begin
                        m_link[s] = m_head;
                        m_link[m_tail] = 5'(s);
                        if (b.opcode == OP_APPEND) m_tail = 5'(s);
                        else m_head = 5'(s);
                    end
                    m_count++;
                    expected_beats.push_back(make_result(STS_OK, s, 1'b1));
                end
            end
            OP_RM_HEAD, OP_RM_KEY: begin
                if (m_count == 0) begin
                    expected_beats.push_back(make_result(STS_EMPTY, -1, 1'b1));
                end else begin
                    if (b.opcode == OP_RM_HEAD) s = int'(m_head);
                    else s = find_first(b.ticket_key, prev);
                    if (s < 0) begin
                        expected_beats.push_back(make_result(STS_NOT_FOUND, -1, 1'b1));
                    end else begin
                        if (m_count <= 1) begin
                            m_head = '0;
                            m_tail = '0;
                        end else if (5'(s) == m_head) begin
                            m_head = m_link[s];
                            m_link[m_tail] = m_head;
                        end else begin
                            m_link[prev] = m_link[s];
                            if (5'(s) == m_tail) m_tail = prev;
                        end
                        m_used[s] = 1'b0;
                        m_count--;
                        expected_beats.push_back(make_result(STS_OK, s, 1'b1));
                    end
                end
            end
            OP_SEARCH, OP_NEXT: begin
                if (m_count == 0) begin
                    expected_beats.push_back(make_result(STS_EMPTY, -1, 1'b1));
                end else begin
                    s = find_first(b.ticket_key, prev);
                    if (s < 0) begin
                        expected_beats.push_back(make_result(STS_NOT_FOUND, -1, 1'b1));
                    end else begin
                        if (b.opcode == OP_NEXT) s = int'(m_link[s]);
                        expected_beats.push_back(make_result(STS_OK, s, 1'b1));
                    end
                end
            end
            OP_COUNT: expected_beats.push_back(make_result(STS_OK, -1, 1'b1));
            default: begin
                if (m_count == 0) begin
                    expected_beats.push_back(make_result(STS_EMPTY, -1, 1'b1));
                end else begin
                    cur = m_head;
                    for (int i = 0; i < m_count; i++) begin
                        expected_beats.push_back(make_result(STS_OK, int'(cur),
                                                             i == m_count - 1));
                        cur = m_link[cur];
                    end
                end
            end
        endcase
    endtask

    function automatic t_in_beat mk_beat(t_op op, logic [15:0] key, logic [15:0] cust,
                                         logic [7:0] ride);
        t_in_beat b;
        b.opcode = op;
        b.ticket_key = key;
        b.customer_handle = cust;
        b.ride_handle = ride;
        return b;
    endfunction

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 2) != 0) return 16'($urandom_range(0, 11));
        return 16'($urandom);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Directed part, then random traffic biased to a small key set.
    initial begin
        t_op op;
        failures = 0;
        stim_done = 1'b0;
        pending_beats.push_back(mk_beat(OP_RM_HEAD, 16'h0, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_RM_KEY, 16'h5, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_SEARCH, 16'h5, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_NEXT, 16'h5, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_LIST, 16'h0, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_COUNT, 16'hffff, 16'hffff, 8'hff));
        pending_beats.push_back(mk_beat(OP_APPEND, 16'h0007, 16'h0000, 8'h00));
        pending_beats.push_back(mk_beat(OP_NEXT, 16'h0007, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_INSERT, 16'hffff, 16'hffff, 8'hff));
        pending_beats.push_back(mk_beat(OP_APPEND, 16'h0007, 16'ha5a5, 8'h5a));
        pending_beats.push_back(mk_beat(OP_SEARCH, 16'h0007, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_NEXT, 16'h0007, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_SEARCH, 16'h1234, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_LIST, 16'h0, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_RM_KEY, 16'h0007, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_RM_HEAD, 16'h0, 16'h0, 8'h0));
        for (int i = 0; i < 34; i++)
            pending_beats.push_back(mk_beat(i[0] ? OP_INSERT : OP_APPEND, 16'(i % 9),
                                            16'($urandom), 8'($urandom)));
        pending_beats.push_back(mk_beat(OP_LIST, 16'h0, 16'h0, 8'h0));
        pending_beats.push_back(mk_beat(OP_NEXT, 16'h0003, 16'h0, 8'h0));
        for (int i = 0; i < 70; i++) begin
            op = t_op'($urandom_range(0, 7));
            if (op == OP_LIST && $urandom_range(0, 2) != 0) op = OP_SEARCH;
            pending_beats.push_back(mk_beat(op, pick_key(), 16'($urandom), 8'($urandom)));
        end
        for (int i = 0; i < 40; i++)
            pending_beats.push_back(mk_beat(OP_RM_HEAD, 16'($urandom), 16'($urandom),
                                            8'($urandom)));
        pending_beats.push_back(mk_beat(OP_LIST, 16'h0, 16'h0, 8'h0));
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_beats.size() == 0);
        repeat (100) @(posedge i_clk);
        if (failures == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    int gap_left;
    int sent;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_beat <= '0;
            gap_left <= $urandom_range(0, 9);
            sent <= 0;
            drain_req <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_list_op(in_beat);
                sent <= sent + 1;
            end
            if (in_valid && in_stall) begin
                // hold beat
            end else if (in_valid && sent == 20) begin
                drain_req <= 1'b1;
                in_valid <= 1'b0;
            end else if (drain_req && !(in_valid && !in_stall)
                         && expected_beats.size() != 0) begin
                in_valid <= 1'b0;
            end else if (gap_left > 0 && !long_hold) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
                if (expected_beats.size() == 0) drain_req <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                in_valid <= 1'b1;
                in_beat <= pending_beats.pop_front();
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                drain_req <= 1'b0;
            end else begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    int stall_left;
    int hold_cycles;
    int rx_beats;
    t_out_beat want;
    initial begin
        in_valid = 1'b0;
        in_beat = '0;
        out_stall = 1'b1;
        long_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
            hold_cycles <= 0;
            rx_beats <= 0;
            long_hold <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                rx_beats <= rx_beats + 1;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, actual %p", $time, out_beat);
                    failures <= failures + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_beat !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, want, out_beat);
                        failures <= failures + 1;
                    end
                end
            end
            if (out_valid && !out_stall && rx_beats == 59 && !long_hold) begin
                long_hold <= 1'b1;
                hold_cycles <= 400;
                out_stall <= 1'b1;
            end else if (long_hold) begin
                hold_cycles <= hold_cycles - 1;
                if (hold_cycles == 1) long_hold <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end
endmodule
`default_nettype wire
